// ===== src/mms_pkg.sv =====
// Shared types and constants for the min/max contrast stretch block.
`default_nettype none
package mms_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned VALUE_W     = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DIV_STEPS   = 8;

   localparam logic [SAMPLE_W-1:0] LOW_INIT  = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0] HIGH_INIT = 16'h0000;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
      logic                last;
   } job_type;

endpackage
`default_nettype wire

// ===== src/minmax_stretch_16_to_8.sv =====
// Top level of the min/max contrast stretch from 16-bit to 8-bit samples.
//
// Command channel: drive start with req_op, req_sample and req_frame_start;
// the command transfers on a rising edge where start is high and busy low.
// A load (req_op 0) stores the sample and widens the frame's min and max;
// req_frame_start on a load begins a new frame first. Loads past
// FRAME_DEPTH samples are dropped. A fetch (req_op 1) returns the next
// stored sample as floor(255*(sample-min)/(max-min)), or its low byte when
// min equals max; rsp_last marks the final loaded sample. A fetch past the
// loaded count returns nothing.
// Results: rsp_valid is high for one cycle with rsp_value and rsp_last;
// the receiver cannot stall, so every result must be taken when shown.
// Timing: a load is stored at its transfer edge. A fetch reads the sample
// RAM (registered read), enters a two-entry job queue and is scaled by one
// shared restoring divider, one quotient bit per cycle, with the result
// registered onto rsp_valid; a flat frame skips the divider. The divider
// takes a new job only once the last one is done. busy rises while the job
// queue, counting a fetch still in its RAM read, has no free slot.
// Reset empties the frame, the queue and the divider; store contents stay
// undefined until loaded.
`default_nettype none
module minmax_stretch_16_to_8
   import mms_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH = 4096
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire                  req_op,
   input  wire  [15:0]          req_sample,
   input  wire                  req_frame_start,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_value,
   output logic                 rsp_last
);

   logic                               push;
   job_type                            push_job;
   logic                               pop;
   job_type                            head_job;
   logic                               empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count;

   mms_front #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .queue_count     (queue_count),
      .push            (push),
      .push_job        (push_job)
   );

   mms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .count    (queue_count)
   );

   mms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );

endmodule
`default_nettype wire

// ===== src/mms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mms_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/mms_queue.sv =====
// Short job queue between the front end and the divider back end.
`default_nettype none
module mms_queue
   import mms_pkg::*;
(
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 push,
   input  wire job_type                        push_job,
   input  wire                                 pop,
   output job_type                             head_job,
   output logic                                empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < CW'(QUEUE_DEPTH))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue underflow");

endmodule
`default_nettype wire

// ===== src/mms_front.sv =====
// Front end: stores samples, tracks extremes and issues fetch jobs.
`default_nettype none
module mms_front
   import mms_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH = 4096
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_op,
   input  wire  [SAMPLE_W-1:0]                 req_sample,
   input  wire                                 req_frame_start,
   input  wire  [$clog2(QUEUE_DEPTH+1)-1:0]    queue_count,
   output logic                                push,
   output job_type                             push_job
);

   localparam int unsigned AW  = $clog2(FRAME_DEPTH);
   localparam int unsigned CW  = $clog2(FRAME_DEPTH + 1);
   localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

   logic                  accept;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [SAMPLE_W-1:0]   low_ff, low_in;
   logic [SAMPLE_W-1:0]   high_ff, high_in;
   logic                  pend_ff, pend_in;
   logic [SAMPLE_W-1:0]   snap_low_ff, snap_low_in;
   logic [SAMPLE_W-1:0]   snap_high_ff, snap_high_in;
   logic                  snap_last_ff, snap_last_in;
   logic                  wr_en;
   logic [SAMPLE_W-1:0]   rd_data;
   logic [CW-1:0]         count_base;
   logic [SAMPLE_W-1:0]   low_base, high_base;

   // Keep one queue slot free for every fetch still waiting on the RAM.
   assign busy   = ({1'b0, queue_count} + (QCW+1)'(pend_ff)) >= (QCW+1)'(QUEUE_DEPTH);
   assign accept = start && !busy;

   always_comb begin
      count_base   = (req_frame_start) ? '0 : count_ff;
      low_base     = (req_frame_start) ? LOW_INIT : low_ff;
      high_base    = (req_frame_start) ? HIGH_INIT : high_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      wr_en        = 1'b0;
      pend_in      = 1'b0;
      snap_low_in  = snap_low_ff;
      snap_high_in = snap_high_ff;
      snap_last_in = snap_last_ff;
      if (accept && req_op == OP_LOAD) begin
         count_in = count_base;
         low_in   = low_base;
         high_in  = high_base;
         if (req_frame_start) begin
            rd_ptr_in = '0;
         end
         // Drop the sample when the store is full.
         if (count_base < CW'(FRAME_DEPTH)) begin
            wr_en    = 1'b1;
            count_in = count_base + CW'(1);
            low_in   = (req_sample < low_base) ? req_sample : low_base;
            high_in  = (req_sample > high_base) ? req_sample : high_base;
         end
      end else if (accept && req_op == OP_FETCH) begin
         if (rd_ptr_ff < count_ff) begin
            pend_in      = 1'b1;
            rd_ptr_in    = rd_ptr_ff + CW'(1);
            snap_low_in  = low_ff;
            snap_high_in = high_ff;
            snap_last_in = (rd_ptr_ff + CW'(1)) == count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         low_ff    <= LOW_INIT;
         high_ff   <= HIGH_INIT;
         pend_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_low_ff  <= snap_low_in;
      snap_high_ff <= snap_high_in;
      snap_last_ff <= snap_last_in;
   end

   mms_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_base[AW-1:0]),
      .wr_data (req_sample),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign push            = pend_ff;
   assign push_job.sample = rd_data;
   assign push_job.low    = snap_low_ff;
   assign push_job.high   = snap_high_ff;
   assign push_job.last   = snap_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FRAME_DEPTH) && rd_ptr_ff <= count_ff)
      else $error("fill count or read pointer out of range");

   a_fetch_pushes: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !$past(pend_ff) || $past(rd_ptr_ff) != rd_ptr_ff || $past(accept))
      else $error("fetch job pushed without a transfer");

endmodule
`default_nettype wire

// ===== src/mms_back.sv =====
// Back end: restoring divider that scales one job to an 8-bit result.
`default_nettype none
module mms_back
   import mms_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  empty,
   input  wire job_type         head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [VALUE_W-1:0]   rsp_value,
   output logic                 rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;
   localparam int unsigned SW = $clog2(DIV_STEPS);

   logic                  state_ff, state_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [SAMPLE_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   den_ff, den_in;
   logic [VALUE_W-1:0]    quo_ff, quo_in;
   logic                  last_ff, last_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  out_last_ff, out_last_in;

   logic [SAMPLE_W-1:0]             range;
   logic [SAMPLE_W-1:0]             off;
   logic [SAMPLE_W+VALUE_W-1:0]     num;
   logic [SAMPLE_W:0]               trial;
   logic                            qbit;

   always_comb begin
      range = head_job.high - head_job.low;
      off   = (head_job.sample >= head_job.low) ? head_job.sample - head_job.low : '0;
      if (off > range) begin
         off = range;
      end
      // 255 * off as a shift and subtract
      num   = {off, {VALUE_W{1'b0}}} - {{VALUE_W{1'b0}}, off};
      trial = {rem_ff, quo_ff[VALUE_W-1]};
      qbit  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      den_in      = den_ff;
      quo_in      = quo_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      valid_in    = 1'b0;
      value_in    = value_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (head_job.high > head_job.low) begin
                  state_in = ST_DIV;
                  step_in  = '0;
                  rem_in   = num[SAMPLE_W+VALUE_W-1:VALUE_W];
                  quo_in   = num[VALUE_W-1:0];
                  den_in   = range;
                  last_in  = head_job.last;
               end else begin
                  // Flat frame: pass the low byte through.
                  valid_in    = 1'b1;
                  value_in    = head_job.sample[VALUE_W-1:0];
                  out_last_in = head_job.last;
               end
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? SAMPLE_W'(trial - {1'b0, den_ff}) : trial[SAMPLE_W-1:0];
            quo_in  = {quo_ff[VALUE_W-2:0], qbit};
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(DIV_STEPS - 1)) begin
               state_in    = ST_IDLE;
               valid_in    = 1'b1;
               value_in    = {quo_ff[VALUE_W-2:0], qbit};
               out_last_in = last_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      last_ff     <= last_in;
      value_ff    <= value_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = out_last_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0 && rem_ff < den_ff)
      else $error("divider running with bad remainder or zero range");

endmodule
`default_nettype wire
